/* rtl/core/ook_switch_code_transmitter_assert.svh */
// ----------------------------------------------------------------------------
// OOK switch code transmitter assertion macros
// Concurrent assertion wrappers for the transmitter RTL; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef OOK_SWITCH_CODE_TRANSMITTER_ASSERT_SVH
`define OOK_SWITCH_CODE_TRANSMITTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clock, off during reset
`define OOK_SCT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ook_switch_code_transmitter: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset
`define OOK_SCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ook_switch_code_transmitter: next-cycle check failed");

`else

`define OOK_SCT_ASSERT_IMPL(label, ante, cons)
`define OOK_SCT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/ook_sct_pkg.sv */
// ----------------------------------------------------------------------------
// OOK switch code transmitter package
// Shared widths, codes, constants and types of the transmitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ook_sct_pkg;

   // Field and register widths
   localparam int BIT_TIME_W  = 10;
   localparam int CAL_W       = 9;
   localparam int PREFIX_W    = 8;
   localparam int CMD_W       = 4;
   localparam int FRAME_LEN   = 12;
   localparam int FRAME_IDX_W = 4;
   localparam int REM_W       = 16;
   localparam int RPT_W       = 3;
   localparam int UNIT_W      = 11;
   localparam int CSR_IDX_W   = 2;

   // Pulse multipliers
   localparam int LONG_FACTOR = 3;
   localparam int SYNC_FACTOR = 31;

   // Defaults
   localparam int REPEATS_DEF = 4;
   localparam logic [BIT_TIME_W-1:0] BIT_TIME_RST = 10'd350;

   // Front to back queue depth
   localparam int Q_DEPTH = 2;

   // Transaction kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_ON   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_OFF  = 2'd2;

   typedef struct packed {
      logic [BIT_TIME_W-1:0] bit_time;
      logic [CAL_W-1:0]      cal_on;
      logic [CAL_W-1:0]      cal_off;
   } cfg_type;

   typedef struct packed {
      logic                 kind;
      logic [FRAME_LEN-1:0] frame;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

/* rtl/core/ook_sct_front.sv */
// ----------------------------------------------------------------------------
// OOK switch code transmitter front end
// Accepts request transactions, classifies them and builds the frame word
// for starts before they enter the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ook_sct_front (
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [ook_sct_pkg::PREFIX_W-1:0]   req_prefix,
   input  logic [ook_sct_pkg::CMD_W-1:0]      req_command,
   input  ook_sct_pkg::q_status_type          q_status,
   output logic                               q_push,
   output ook_sct_pkg::q_entry_type           q_entry
);
   import ook_sct_pkg::*;

   logic [PREFIX_W-1:0] prefix_rev;

   // Take a transaction whenever the queue has room
   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready;

   // Reverse the prefix bit order within each nibble
   assign prefix_rev = {req_prefix[4], req_prefix[5], req_prefix[6], req_prefix[7],
                        req_prefix[0], req_prefix[1], req_prefix[2], req_prefix[3]};

   // Build the queue entry; ticks carry no frame
   always_comb begin
      q_entry.kind = req_kind;
      unique case (req_kind)
         KIND_START: q_entry.frame = {prefix_rev, req_command};
         default:    q_entry.frame = '0;
      endcase
   end

endmodule

/* rtl/core/ook_sct_queue.sv */
// ----------------------------------------------------------------------------
// OOK switch code transmitter queue
// Short FIFO that decouples the front end from the waveform engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ook_sct_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ook_sct_pkg::q_entry_type  push_entry,
   input  logic                      pop,
   output ook_sct_pkg::q_entry_type  pop_entry,
   output ook_sct_pkg::q_status_type status
);
   import ook_sct_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   q_entry_type             entry_ff [Q_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   // Track fill level
   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry        = entry_ff[rd_ptr_ff];
   assign status.full      = (count_ff == CNT_W'(Q_DEPTH));
   assign status.not_empty = (count_ff != '0);

endmodule

/* rtl/core/ook_sct_engine.sv */
// ----------------------------------------------------------------------------
// OOK switch code transmitter waveform engine
// Pops one transaction per cycle while the response slot is free, steps
// the pulse sequencer and registers the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ook_sct_engine #(
   parameter int REPEATS = ook_sct_pkg::REPEATS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ook_sct_pkg::cfg_type      cfg,
   input  ook_sct_pkg::q_status_type q_status,
   input  ook_sct_pkg::q_entry_type  q_entry,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_pin_level,
   output logic                      rsp_busy_res,
   output logic                      rsp_done_res
);
   import ook_sct_pkg::*;

   // Sequencer state
   logic [FRAME_LEN-1:0]   frame_ff, frame_in;
   logic [RPT_W-1:0]       repeat_ff, repeat_in;
   logic [FRAME_IDX_W-1:0] bit_idx_ff, bit_idx_in;
   logic                   second_ff, second_in;
   logic                   high_ff, high_in;
   logic                   sync_ff, sync_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic                   active_ff, active_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   pin_ff, busy_ff, done_ff;

   logic                   advance;
   logic                   done_now;
   logic                   load_high, load_low;
   logic [RPT_W-1:0]       repeat_inc;
   logic [FRAME_IDX_W-1:0] bit_idx_inc;
   logic [FRAME_IDX_W-1:0] frame_sel;
   logic                   cur_bit, long_high;
   logic [UNIT_W-1:0]      u_on, u_off;
   logic [REM_W-1:0]       on_short, on_long, off_short, off_long, off_sync;

   // Clamp base plus calibration to at least one tick
   function automatic logic [UNIT_W-1:0] unit_of(input logic [BIT_TIME_W-1:0] base,
                                                 input logic [CAL_W-1:0] cal);
      logic signed [UNIT_W:0] sum;
      sum = $signed({2'b00, base}) + $signed({{(UNIT_W + 1 - CAL_W){cal[CAL_W-1]}}, cal});
      if (sum[UNIT_W] || (sum == '0)) begin
         return UNIT_W'(1);
      end
      return sum[UNIT_W-1:0];
   endfunction

   // Consume a queued transaction when the response slot frees up
   assign advance      = q_status.not_empty && (!rsp_valid_ff || rsp_ready);
   assign q_pop        = advance;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Pulse units and durations
   assign u_on      = unit_of(cfg.bit_time, cfg.cal_on);
   assign u_off     = unit_of(cfg.bit_time, cfg.cal_off);
   assign on_short  = REM_W'(u_on);
   assign on_long   = REM_W'(u_on) * REM_W'(LONG_FACTOR);
   assign off_short = REM_W'(u_off);
   assign off_long  = REM_W'(u_off) * REM_W'(LONG_FACTOR);
   assign off_sync  = REM_W'(u_off) * REM_W'(SYNC_FACTOR);

   assign repeat_inc  = repeat_ff + 1'b1;
   assign bit_idx_inc = bit_idx_ff + 1'b1;

   // Step the sequencer for one transaction
   always_comb begin
      frame_in   = frame_ff;
      repeat_in  = repeat_ff;
      bit_idx_in = bit_idx_ff;
      second_in  = second_ff;
      high_in    = high_ff;
      sync_in    = sync_ff;
      rem_in     = rem_ff;
      active_in  = active_ff;
      done_now   = 1'b0;
      load_high  = 1'b0;
      load_low   = 1'b0;
      if (q_entry.kind == KIND_START) begin
         if (!active_ff) begin
            frame_in   = q_entry.frame;
            repeat_in  = '0;
            bit_idx_in = '0;
            second_in  = 1'b0;
            sync_in    = 1'b0;
            active_in  = 1'b1;
            load_high  = 1'b1;
         end
      end else if (active_ff) begin
         priority if (rem_ff > REM_W'(1)) begin
            rem_in = rem_ff - 1'b1;
         end else if (high_ff) begin
            load_low = 1'b1;
         end else if (sync_ff) begin
            repeat_in = repeat_inc;
            if (repeat_inc >= RPT_W'(REPEATS)) begin
               active_in = 1'b0;
               high_in   = 1'b0;
               sync_in   = 1'b0;
               rem_in    = '0;
               done_now  = 1'b1;
            end else begin
               sync_in    = 1'b0;
               bit_idx_in = '0;
               second_in  = 1'b0;
               load_high  = 1'b1;
            end
         end else if (!second_ff) begin
            second_in = 1'b1;
            load_high = 1'b1;
         end else begin
            second_in  = 1'b0;
            bit_idx_in = bit_idx_inc;
            if (bit_idx_inc >= FRAME_IDX_W'(FRAME_LEN)) begin
               sync_in = 1'b1;
            end
            load_high = 1'b1;
         end
      end

      // Pick the frame bit of the pulse about to start
      frame_sel = FRAME_IDX_W'(FRAME_LEN - 1) - bit_idx_in;
      cur_bit   = (bit_idx_in < FRAME_IDX_W'(FRAME_LEN)) ? frame_in[frame_sel] : 1'b0;
      long_high = !sync_in && second_in && cur_bit;

      // Load the next phase duration
      if (load_high) begin
         high_in = 1'b1;
         rem_in  = long_high ? on_long : on_short;
      end else if (load_low) begin
         high_in = 1'b0;
         if (sync_in) begin
            rem_in = off_sync;
         end else if (long_high) begin
            rem_in = off_short;
         end else begin
            rem_in = off_long;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_ff    <= '0;
         bit_idx_ff   <= '0;
         second_ff    <= 1'b0;
         high_ff      <= 1'b0;
         sync_ff      <= 1'b0;
         rem_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            repeat_ff  <= repeat_in;
            bit_idx_ff <= bit_idx_in;
            second_ff  <= second_in;
            high_ff    <= high_in;
            sync_ff    <= sync_in;
            rem_ff     <= rem_in;
            active_ff  <= active_in;
         end
      end
   end

   // Hold frame and response payload
   always_ff @(posedge clock) begin
      if (advance) begin
         frame_ff <= frame_in;
         pin_ff   <= active_in && high_in;
         busy_ff  <= active_in;
         done_ff  <= done_now;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_level = pin_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;

endmodule

/* rtl/core/ook_switch_code_transmitter.sv */
// ----------------------------------------------------------------------------
// OOK switch code transmitter
// Path: an accepted request transaction is written into the queue, and its
// response is then held in the engine's response register.
// Throughput: one transaction per cycle while responses are not stalled.
// Reset: synchronous; clears sequencer and queue, registers take defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ook_switch_code_transmitter_assert.svh"

module ook_switch_code_transmitter #(
   parameter int REPEATS = ook_sct_pkg::REPEATS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [ook_sct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ook_sct_pkg::BIT_TIME_W-1:0]   csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [ook_sct_pkg::PREFIX_W-1:0]     req_prefix,
   input  logic [ook_sct_pkg::CMD_W-1:0]        req_command,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_pin_level,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res
);
   import ook_sct_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   q_entry_type  push_entry, pop_entry;
   logic         q_push, q_pop;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BIT_TIME: cfg_in.bit_time = csr_wdata;
            CSR_CAL_ON:   cfg_in.cal_on   = csr_wdata[CAL_W-1:0];
            CSR_CAL_OFF:  cfg_in.cal_off  = csr_wdata[CAL_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_time <= BIT_TIME_RST;
         cfg_ff.cal_on   <= '0;
         cfg_ff.cal_off  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ook_sct_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_prefix  (req_prefix),
      .req_command (req_command),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   ook_sct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   ook_sct_engine #(
      .REPEATS (REPEATS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_status      (q_status),
      .q_entry       (pop_entry),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pin_level (rsp_pin_level),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res)
   );

   // Accepted transaction is in the queue on the next cycle
   `OOK_SCT_ASSERT_NEXT(a_push_lands, req_valid && req_ready, q_status.not_empty)
   // Final tick ends the transmission with the carrier off
   `OOK_SCT_ASSERT_IMPL(a_done_idle, rsp_valid && rsp_done_res, !rsp_busy_res && !rsp_pin_level)
   // Carrier is keyed only during a transmission
   `OOK_SCT_ASSERT_IMPL(a_pin_busy, rsp_valid && rsp_pin_level, rsp_busy_res)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK switch code transmitter testbench
// Drives start and tick transactions through the request channel. A cycle
// model of the pulse sequencer predicts the keying level, busy and done flags
// of every response. A short table of directed rows is followed by random
// phases that rewrite the pulse-unit registers, run transmissions and visit
// the register extremes once the transmitter goes idle, with random stalls on
// both channels.
// ----------------------------------------------------------------------------

module tb_top;
   import ook_sct_pkg::*;

   localparam int IDLE_LIMIT    = 500;
   localparam int RANDOM_ITEMS  = 900;
   localparam int EXTREME_SETS  = 2;
   localparam int DIRECTED_ROWS = 10;

   typedef struct packed {
      logic pin;
      logic busy;
      logic done;
   } keying_type;

   typedef struct packed {
      logic                kind;
      logic [PREFIX_W-1:0] prefix;
      logic [CMD_W-1:0]    command;
      logic                typed;
      keying_type          want;
   } stim_row_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [BIT_TIME_W-1:0] csr_wdata   = '0;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic                  req_kind    = KIND_TICK;
   logic [PREFIX_W-1:0]   req_prefix  = '0;
   logic [CMD_W-1:0]      req_command = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic                  rsp_pin_level;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;

   ook_switch_code_transmitter dut (.*);

   // Sequencer model: register copies and waveform state
   logic [BIT_TIME_W-1:0]   bit_time_reg = BIT_TIME_RST;
   logic signed [CAL_W-1:0] cal_on_reg   = '0;
   logic signed [CAL_W-1:0] cal_off_reg  = '0;
   logic [FRAME_LEN-1:0]    frame_bits   = '0;
   logic [RPT_W-1:0]        repeat_cnt   = '0;
   logic [FRAME_IDX_W-1:0]  bit_pos      = '0;
   logic                    second_pulse = 1'b0;
   logic                    in_high      = 1'b0;
   logic                    in_sync      = 1'b0;
   logic                    sending      = 1'b0;
   logic [REM_W-1:0]        ticks_left   = '0;

   keying_type expected_keying[$];
   int      mismatches         = 0;
   int      transmissions_done = 0;
   int      stall_left         = 0;
   int      idle_cycles        = 0;
   bit      quiet_phase        = 1'b0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{KIND_TICK,  8'h00, 4'h0, 1'b1, 3'b000},
      '{KIND_TICK,  8'hFF, 4'hF, 1'b1, 3'b000},
      '{KIND_START, 8'hFF, 4'hF, 1'b1, 3'b110},
      '{KIND_START, 8'h00, 4'h0, 1'b1, 3'b110},
      '{KIND_START, 8'hA5, 4'h3, 1'b1, 3'b110},
      '{KIND_TICK,  8'h5A, 4'hC, 1'b0, 3'b000},
      '{KIND_TICK,  8'h00, 4'h0, 1'b0, 3'b000},
      '{KIND_TICK,  8'hFF, 4'hF, 1'b0, 3'b000},
      '{KIND_TICK,  8'h3C, 4'h9, 1'b0, 3'b000},
      '{KIND_TICK,  8'hC3, 4'h6, 1'b0, 3'b000}
   };

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Pulse unit from the base time and a signed calibration, never below one
   function automatic logic [REM_W-1:0] pulse_unit(logic signed [CAL_W-1:0] cal);
      int sum;
      sum = int'(bit_time_reg) + int'(cal);
      if (sum < 1) sum = 1;
      return sum[REM_W-1:0];
   endfunction

   function automatic logic frame_bit();
      if (bit_pos >= FRAME_LEN) return 1'b0;
      return frame_bits[FRAME_LEN-1-bit_pos];
   endfunction

   // Second pulse of a one bit keeps the carrier on for the long part
   function automatic logic long_high();
      return !in_sync && second_pulse && frame_bit();
   endfunction

   function automatic void load_high();
      logic [REM_W-1:0] u;
      u = pulse_unit(cal_on_reg);
      in_high = 1'b1;
      ticks_left = long_high() ? REM_W'(LONG_FACTOR * u) : u;
   endfunction

   function automatic void load_low();
      logic [REM_W-1:0] u;
      u = pulse_unit(cal_off_reg);
      in_high = 1'b0;
      if (in_sync) ticks_left = REM_W'(SYNC_FACTOR * u);
      else if (long_high()) ticks_left = u;
      else ticks_left = REM_W'(LONG_FACTOR * u);
   endfunction

   // Advance to the next pulse half; return 1 when the last repeat ends
   function automatic logic close_phase();
      if (in_high) begin
         load_low();
         return 1'b0;
      end
      if (in_sync) begin
         repeat_cnt = repeat_cnt + 1'b1;
         if (repeat_cnt >= REPEATS_DEF) begin
            sending    = 1'b0;
            in_high    = 1'b0;
            in_sync    = 1'b0;
            ticks_left = '0;
            return 1'b1;
         end
         in_sync      = 1'b0;
         bit_pos      = '0;
         second_pulse = 1'b0;
      end else if (!second_pulse) begin
         second_pulse = 1'b1;
      end else begin
         second_pulse = 1'b0;
         bit_pos = bit_pos + 1'b1;
         if (bit_pos >= FRAME_LEN) in_sync = 1'b1;
      end
      load_high();
      return 1'b0;
   endfunction

   // Predict the response to one request transaction
   function automatic keying_type keyer_step(logic kind, logic [PREFIX_W-1:0] prefix,
                                             logic [CMD_W-1:0] command);
      logic       finished;
      keying_type res;
      finished = 1'b0;
      if (kind == KIND_START) begin
         if (!sending) begin
            frame_bits = {prefix[4], prefix[5], prefix[6], prefix[7],
                          prefix[0], prefix[1], prefix[2], prefix[3], command};
            repeat_cnt   = '0;
            bit_pos      = '0;
            second_pulse = 1'b0;
            in_sync      = 1'b0;
            sending      = 1'b1;
            load_high();
         end
      end else if (sending) begin
         if (ticks_left > 1) ticks_left = ticks_left - 1'b1;
         else finished = close_phase();
      end
      res.pin  = sending && in_high;
      res.busy = sending;
      res.done = finished;
      return res;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic compare_bit(string field, logic want, logic got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %b actual %b", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Present one request transaction, hold it until accepted, then log the expectation
   task automatic send_item(logic kind, logic [PREFIX_W-1:0] prefix, logic [CMD_W-1:0] command,
                            logic typed, keying_type want);
      keying_type got;
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_prefix  <= prefix;
      req_command <= command;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = keyer_step(kind, prefix, command);
      if (got.done) transmissions_done++;
      expected_keying.push_back(typed ? want : got);
      if (!quiet_phase && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every response is back and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_keying.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [BIT_TIME_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_BIT_TIME: bit_time_reg = data;
         CSR_CAL_ON:   cal_on_reg   = data[CAL_W-1:0];
         CSR_CAL_OFF:  cal_off_reg  = data[CAL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic [BIT_TIME_W-1:0] bt, logic signed [CAL_W-1:0] con,
                                logic signed [CAL_W-1:0] coff);
      write_reg(CSR_BIT_TIME, bt);
      write_reg(CSR_CAL_ON, {1'b0, con});
      write_reg(CSR_CAL_OFF, {1'b0, coff});
      csr_wr_en <= 1'b0;
   endtask

   // Stimulus: reset, directed table, then random phases
   initial begin
      int                      items;
      int                      n;
      int                      k;
      int                      phase;
      int                      ext_step;
      bit                      extreme;
      logic                    kind;
      logic [BIT_TIME_W-1:0]   bt;
      logic signed [CAL_W-1:0] con;
      logic signed [CAL_W-1:0] coff;

      items    = 0;
      phase    = 0;
      ext_step = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table at reset register values
      for (k = 0; k < DIRECTED_ROWS; k++) begin
         send_item(directed_rows[k].kind, directed_rows[k].prefix, directed_rows[k].command,
                   directed_rows[k].typed, directed_rows[k].want);
      end

      while (phase < 400 && items < RANDOM_ITEMS) begin
         settle();
         quiet_phase = ($urandom_range(0, 3) == 0);
         extreme = !sending && ext_step < EXTREME_SETS && transmissions_done > 0;

         // Pick register values: extremes right after a completion, else short units
         if (extreme) begin
            if (ext_step == 0) apply_setting(10'd1023, -9'sd255, 9'sd255);
            else apply_setting(10'd1, 9'sd255, -9'sd255);
            ext_step++;
            n = $urandom_range(5, 20);
         end else begin
            bt = BIT_TIME_W'($urandom_range(1, 3));
            if ($urandom_range(0, 3) == 0) begin
               con  = CAL_W'(-$urandom_range(3, 255));
               coff = CAL_W'(-$urandom_range(0, 255));
            end else begin
               con  = CAL_W'($urandom_range(0, 6) - 3);
               coff = CAL_W'($urandom_range(0, 6) - 3);
            end
            apply_setting(bt, con, coff);
            n = $urandom_range(60, 250);
         end

         for (k = 0; k < n && items < RANDOM_ITEMS; k++) begin
            // End the phase on completion so the next one can load extremes
            if (!extreme && !sending && ext_step < EXTREME_SETS && transmissions_done > 0)
               break;
            if (!sending) kind = (extreme || $urandom_range(0, 9) != 0) ? KIND_START : KIND_TICK;
            else kind = ($urandom_range(0, 32) == 0) ? KIND_START : KIND_TICK;
            send_item(kind, PREFIX_W'($urandom_range(0, 255)), CMD_W'($urandom_range(0, 15)),
                      1'b0, '0);
            items++;
         end
         phase++;
      end

      // Drain outstanding responses, then report
      req_valid <= 1'b0;
      while (expected_keying.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Check responses in order and throttle the response channel
   always @(posedge clock) begin
      keying_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_keying.size() == 0) begin
            $display("%0t: unexpected response, expected none actual pin=%b busy=%b done=%b",
                     $time, rsp_pin_level, rsp_busy_res, rsp_done_res);
            mismatches++;
         end else begin
            want = expected_keying.pop_front();
            compare_bit("pin_level", want.pin, rsp_pin_level);
            compare_bit("busy_res", want.busy, rsp_busy_res);
            compare_bit("done_res", want.done, rsp_done_res);
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 99) < 20) begin
         stall_left = pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Abort when no transaction moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses outstanding", $time,
                  expected_keying.size());
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ook_sct_pkg.sv
rtl/core/ook_sct_front.sv
rtl/core/ook_sct_queue.sv
rtl/core/ook_sct_engine.sv
rtl/core/ook_switch_code_transmitter.sv
tb/tb_top.sv
